// ===== rtl/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared widths, register indexes and the controller/datapath command and
// status types of the trapezoidal pulse measure unit.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_DELAY      = 512;
  localparam int ADDR_BITS      = 9;
  localparam int FILL_BITS      = 10;
  localparam int INDEX_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // shared restoring divider
  localparam int DIV_N_BITS   = 74;
  localparam int DIV_D_BITS   = 34;
  localparam int DIV_Q_BITS   = 48;
  localparam int DIV_CNT_BITS = 7;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASELINE_LEN   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RISE_LEN       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FLAT_LEN       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_MAG      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INFINITE_DECAY = 3'd4;

  typedef enum logic [1:0] {
    TAP_K,
    TAP_L,
    TAP_KL
  } tap_t;

  typedef enum logic [1:0] {
    DIV_FILT,
    DIV_MEAN,
    DIV_NOISE
  } div_op_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    tap_t    rd_sel;
    logic    cap_en;
    tap_t    cap_sel;
    logic    calc_d;
    logic    acc_mul;
    logic    acc_shape;
    logic    take_mag;
    logic    div_start;
    div_op_t div_sel;
    logic    take_peak;
    logic    base_prep;
    logic    take_num;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    load_out;
  } tpm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic last;
    logic n_gt1;
    logic sqrt_last;
    logic out_free;
  } tpm_status_t;

endpackage

// ===== rtl/tpm_in_if.sv =====
// ----------------------------------------------------------------------------
// tpm_in_if
// Sample channel: valid/ready handshake with one waveform sample per item.
// ----------------------------------------------------------------------------
interface tpm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== rtl/tpm_out_if.sv =====
// ----------------------------------------------------------------------------
// tpm_out_if
// Result channel: filtered value per item plus the waveform summary.
// ----------------------------------------------------------------------------
interface tpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered;
  logic               summary_valid;
  logic signed [23:0] baseline_mean;
  logic        [23:0] baseline_noise;
  logic        [15:0] peak_index;
  logic signed [31:0] peak_value;

  modport source (output valid, output filtered, output summary_valid,
                  output baseline_mean, output baseline_noise, output peak_index,
                  output peak_value, input ready);
  modport sink   (input valid, input filtered, input summary_valid,
                  input baseline_mean, input baseline_noise, input peak_index,
                  input peak_value, output ready);
endinterface

// ===== rtl/trapezoidal_pulse_measure_unit.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_pulse_measure_unit
// Trapezoidal shaping filter over one waveform with baseline and peak summary.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An ordinary sample goes through tap reads
// on the single-port delay line and accumulation, the bit-serial divider that
// forms the rounded q.8 output, then peak tracking and the result register.
// The item marked last adds up to two more passes of the same divider
// (baseline mean and variance) and 24 square root steps. A result waiting
// in the output register does not block acceptance of the next sample.
// No clearing pass is needed after reset.
module trapezoidal_pulse_measure_unit (
  input  logic                               clk,
  input  logic                               rst,
  tpm_in_if.sink                             stream_in,
  tpm_out_if.source                          stream_out,
  input  logic                               cfg_we,
  input  logic [tpm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tpm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  tpm_pkg::tpm_cmd_t    cmd;
  tpm_pkg::tpm_status_t status;

  tpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream_in.valid),
    .in_ready (stream_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tpm_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_sample          (stream_in.sample),
    .in_last            (stream_in.last),
    .cmd                (cmd),
    .status             (status),
    .out_ready          (stream_out.ready),
    .out_valid          (stream_out.valid),
    .out_filtered       (stream_out.filtered),
    .out_summary_valid  (stream_out.summary_valid),
    .out_baseline_mean  (stream_out.baseline_mean),
    .out_baseline_noise (stream_out.baseline_noise),
    .out_peak_index     (stream_out.peak_index),
    .out_peak_value     (stream_out.peak_value)
  );

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    stream_in.valid && stream_in.ready |=> !stream_in.ready)
    else $error("item accepted while previous item still in work");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result register overwritten before taken");

endmodule

// ===== rtl/tpm_div.sv =====
// ----------------------------------------------------------------------------
// tpm_div
// Restoring divider, one quotient bit per cycle, with a sticky flag for
// quotient bits above the kept width.
// ----------------------------------------------------------------------------
module tpm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tpm_pkg::DIV_N_BITS-1:0]   dividend,
  input  logic [tpm_pkg::DIV_D_BITS-1:0]   divisor,
  output logic                             busy,
  output logic                             done,
  output logic [tpm_pkg::DIV_Q_BITS-1:0]   quotient,
  output logic                             overflow
);

  logic [tpm_pkg::DIV_D_BITS-1:0]   rem;
  logic [tpm_pkg::DIV_N_BITS-1:0]   dvd;
  logic [tpm_pkg::DIV_D_BITS-1:0]   dvs;
  logic [tpm_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [tpm_pkg::DIV_D_BITS:0]     trial;
  logic                             fits;

  always_comb begin
    trial = {rem, dvd[tpm_pkg::DIV_N_BITS-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= tpm_pkg::DIV_CNT_BITS'(tpm_pkg::DIV_N_BITS);
        rem      <= '0;
        dvd      <= dividend;
        dvs      <= divisor;
        quotient <= '0;
        overflow <= 1'b0;
      end else if (busy) begin
        rem      <= fits ? tpm_pkg::DIV_D_BITS'(trial - {1'b0, dvs})
                         : tpm_pkg::DIV_D_BITS'(trial);
        dvd      <= {dvd[tpm_pkg::DIV_N_BITS-2:0], 1'b0};
        quotient <= {quotient[tpm_pkg::DIV_Q_BITS-2:0], fits};
        overflow <= overflow | quotient[tpm_pkg::DIV_Q_BITS-1];
        cnt      <= cnt - 1'b1;
        if (cnt == tpm_pkg::DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tpm_datapath.sv =====
// ----------------------------------------------------------------------------
// tpm_datapath
// Delay line, shaper accumulators, baseline sums, peak tracking, divider,
// square root iteration and the result register.
// ----------------------------------------------------------------------------
module tpm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tpm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [tpm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic signed [tpm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                  in_last,
  input  tpm_pkg::tpm_cmd_t                     cmd,
  output tpm_pkg::tpm_status_t                  status,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [31:0]                    out_filtered,
  output logic                                  out_summary_valid,
  output logic signed [23:0]                    out_baseline_mean,
  output logic        [23:0]                    out_baseline_noise,
  output logic        [15:0]                    out_peak_index,
  output logic signed [31:0]                    out_peak_value
);

  // configuration
  logic [12:0] baseline_len;
  logic [8:0]  rise_len;
  logic [8:0]  flat_len;
  logic [23:0] decay_mag;
  logic        infinite_decay;

  // item and taps
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] v;
  logic                                   last_r;
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] vk, vl, vkl;
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] rd_data;
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] mem [tpm_pkg::MAX_DELAY];
  logic [tpm_pkg::ADDR_BITS-1:0]          wr_pos;
  logic [tpm_pkg::FILL_BITS-1:0]          filled;
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] first_sample;
  logic [tpm_pkg::INDEX_BITS-1:0]         sample_index;

  // shaper
  logic signed [18:0] d;
  logic [32:0]        den;
  logic [55:0]        slope_acc;
  logic signed [43:0] prod;
  logic [63:0]        shape_acc;
  logic [63:0]        mag;
  logic               mag_neg;

  // baseline and summary
  logic [12:0]        base_cnt;
  logic signed [31:0] base_sum;
  logic [47:0]        base_sq_sum;
  logic [31:0]        bmag;
  logic [57:0]        nsq;
  logic [57:0]        ssq;
  logic [57:0]        num;
  logic [25:0]        nden;
  logic signed [23:0] mean;
  logic signed [31:0] y;
  logic signed [31:0] best_value;
  logic [15:0]        best_index;
  logic [47:0]        sx, sr, sbit;

  // combinational
  logic [tpm_pkg::FILL_BITS-1:0]          dd_k, dd_l, dd_kl, kl_sum, rd_dd, cap_dd;
  logic [tpm_pkg::ADDR_BITS-1:0]          rd_addr;
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] cap_val;
  logic [8:0]                             kp;
  logic [23:0]                            mp;
  logic [tpm_pkg::DIV_N_BITS-1:0]         div_dvd;
  logic [tpm_pkg::DIV_D_BITS-1:0]         div_dvs;
  logic                                   div_busy, div_done, div_ovf;
  logic [tpm_pkg::DIV_Q_BITS-1:0]         div_q;
  logic                                   big;
  logic signed [31:0]                     y_c;
  logic signed [31:0]                     vsq;
  logic signed [63:0]                     sum_sq_full;
  logic [63:0]                            nsq_full;
  logic [47:0]                            s_try;

  always_comb begin
    kl_sum = {1'b0, rise_len} + {1'b0, flat_len};
    dd_k   = {1'b0, rise_len};
    dd_l   = {1'b0, flat_len};
    dd_kl  = (kl_sum > tpm_pkg::FILL_BITS'(tpm_pkg::MAX_DELAY))
           ? tpm_pkg::FILL_BITS'(tpm_pkg::MAX_DELAY) : kl_sum;
    case (cmd.rd_sel)
      tpm_pkg::TAP_K:  rd_dd = dd_k;
      tpm_pkg::TAP_L:  rd_dd = dd_l;
      tpm_pkg::TAP_KL: rd_dd = dd_kl;
      default:         rd_dd = dd_k;
    endcase
    case (cmd.cap_sel)
      tpm_pkg::TAP_K:  cap_dd = dd_k;
      tpm_pkg::TAP_L:  cap_dd = dd_l;
      tpm_pkg::TAP_KL: cap_dd = dd_kl;
      default:         cap_dd = dd_k;
    endcase
    // a delay of the full depth lands on wr_pos, the oldest entry
    rd_addr = wr_pos - rd_dd[tpm_pkg::ADDR_BITS-1:0];
    if (cap_dd == '0)        cap_val = v;
    else if (cap_dd > filled) cap_val = first_sample;
    else                      cap_val = rd_data;

    kp = (rise_len == '0) ? 9'd1 : rise_len;
    mp = (decay_mag == '0) ? 24'd1 : decay_mag;

    case (cmd.div_sel)
      tpm_pkg::DIV_FILT: begin
        div_dvd = tpm_pkg::DIV_N_BITS'({mag, 9'b0}) + tpm_pkg::DIV_N_BITS'(den);
        div_dvs = tpm_pkg::DIV_D_BITS'({den, 1'b0});
      end
      tpm_pkg::DIV_MEAN: begin
        div_dvd = tpm_pkg::DIV_N_BITS'({bmag, 9'b0}) + tpm_pkg::DIV_N_BITS'(base_cnt);
        div_dvs = tpm_pkg::DIV_D_BITS'({base_cnt, 1'b0});
      end
      tpm_pkg::DIV_NOISE: begin
        div_dvd = {num, 16'b0};
        div_dvs = tpm_pkg::DIV_D_BITS'(nden);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase

    // rounded quotient to q.8 with saturation
    big = div_ovf | (|div_q[tpm_pkg::DIV_Q_BITS-1:31]);
    if (mag_neg) y_c = big ? 32'sh8000_0000 : -$signed(div_q[31:0]);
    else         y_c = big ? 32'sh7fff_ffff : $signed(div_q[31:0]);

    vsq         = 32'(v) * 32'(v);
    sum_sq_full = 64'(base_sum) * 64'(base_sum);
    nsq_full    = 64'(base_cnt) * 64'(base_sq_sum);
    s_try       = sr + sbit;
  end

  tpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .overflow (div_ovf)
  );

  always_comb begin
    status.div_busy  = div_busy;
    status.div_done  = div_done;
    status.last      = last_r;
    status.n_gt1     = base_cnt > 13'd1;
    status.sqrt_last = sbit[0];
    status.out_free  = !out_valid || out_ready;
  end

  // delay line
  always_ff @(posedge clk) begin
    if (cmd.acc_mul) mem[wr_pos] <= v;
    if (cmd.rd_en)   rd_data <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v      <= in_sample;
      last_r <= in_last;
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        tpm_pkg::TAP_K:  vk  <= cap_val;
        tpm_pkg::TAP_L:  vl  <= cap_val;
        tpm_pkg::TAP_KL: vkl <= cap_val;
        default:         vk  <= cap_val;
      endcase
    end
    if (cmd.calc_d) begin
      d   <= 19'(v) - 19'(vk) - 19'(vl) + 19'(vkl);
      den <= 33'(kp) * 33'(mp);
    end
    if (cmd.acc_mul)  prod <= d * $signed({1'b0, decay_mag});
    if (cmd.take_mag) begin
      mag_neg <= shape_acc[63];
      mag     <= shape_acc[63] ? -shape_acc : shape_acc;
    end
    if (cmd.take_peak) y <= y_c;
    if (cmd.base_prep) begin
      bmag <= base_sum[31] ? 32'(-base_sum) : 32'(base_sum);
      nsq  <= nsq_full[57:0];
      ssq  <= sum_sq_full[57:0];
    end
    if (cmd.take_num) begin
      num  <= nsq - ssq;
      nden <= 26'(26'(base_cnt) * 26'(base_cnt - 13'd1));
      if (base_cnt == '0)   mean <= '0;
      else if (base_sum[31]) mean <= -$signed(div_q[23:0]);
      else                   mean <= $signed(div_q[23:0]);
    end
    if (cmd.sqrt_init) begin
      sx   <= div_q;
      sr   <= '0;
      sbit <= 48'(1) << 46;
    end else if (cmd.sqrt_step) begin
      if (sx >= s_try) begin
        sx <= sx - s_try;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.load_out) begin
      out_filtered       <= y;
      out_summary_valid  <= last_r;
      out_baseline_mean  <= last_r ? mean : '0;
      out_baseline_noise <= (last_r && status.n_gt1) ? sr[23:0] : '0;
      out_peak_index     <= last_r ? best_index : '0;
      out_peak_value     <= last_r ? best_value : '0;
    end
  end

  // configuration and waveform state
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_len   <= 13'd16;
      rise_len       <= 9'd16;
      flat_len       <= 9'd8;
      decay_mag      <= 24'd25600;
      infinite_decay <= 1'b0;
      out_valid      <= 1'b0;
      wr_pos         <= '0;
      filled         <= '0;
      first_sample   <= '0;
      sample_index   <= '0;
      slope_acc      <= '0;
      shape_acc      <= '0;
      base_cnt       <= '0;
      base_sum       <= '0;
      base_sq_sum    <= '0;
      best_value     <= 32'sh8000_0000;
      best_index     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpm_pkg::CFG_BASELINE_LEN:   baseline_len   <= cfg_data[12:0];
          tpm_pkg::CFG_RISE_LEN:       rise_len       <= cfg_data[8:0];
          tpm_pkg::CFG_FLAT_LEN:       flat_len       <= cfg_data[8:0];
          tpm_pkg::CFG_DECAY_MAG:      decay_mag      <= cfg_data;
          tpm_pkg::CFG_INFINITE_DECAY: infinite_decay <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.capture && filled == '0) first_sample <= in_sample;

      if (cmd.acc_mul) begin
        slope_acc <= slope_acc + 56'(d);
        wr_pos    <= wr_pos + 1'b1;
        if (filled < tpm_pkg::FILL_BITS'(tpm_pkg::MAX_DELAY)) filled <= filled + 1'b1;
        if (base_cnt < baseline_len) begin
          base_sum    <= base_sum + 32'(v);
          base_sq_sum <= base_sq_sum + 48'(vsq);
          base_cnt    <= base_cnt + 1'b1;
        end
      end

      if (cmd.acc_shape) begin
        if (infinite_decay) shape_acc <= shape_acc + (64'(d) <<< 8);
        else                shape_acc <= shape_acc + {slope_acc, 8'b0} + 64'(prod);
      end

      if (cmd.take_peak) begin
        if (y_c > best_value) begin
          best_value <= y_c;
          best_index <= sample_index;
        end
        if (sample_index != '1) sample_index <= sample_index + 1'b1;
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (last_r) begin
          // start of a new waveform
          wr_pos       <= '0;
          filled       <= '0;
          first_sample <= '0;
          sample_index <= '0;
          slope_acc    <= '0;
          shape_acc    <= '0;
          base_cnt     <= '0;
          base_sum     <= '0;
          base_sq_sum  <= '0;
          best_value   <= 32'sh8000_0000;
          best_index   <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpm_ctrl
// Sequencer: tap reads, accumulation, filter division, and on the last item
// the baseline mean and, with two or more baseline samples, the variance division and square root.
// ----------------------------------------------------------------------------
module tpm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tpm_pkg::tpm_status_t status,
  output tpm_pkg::tpm_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_K, S_RD_L, S_RD_KL, S_CAP_KL, S_DIFF, S_MUL, S_SHAPE, S_MAG,
    S_FDIV, S_FWAIT, S_PEAK, S_BPREP, S_MDIV, S_MWAIT, S_NUM, S_NDIV, S_NWAIT,
    S_SQINIT, S_SQRT, S_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_RD_K;
      end
      S_RD_K: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tpm_pkg::TAP_K;
        state_next = S_RD_L;
      end
      S_RD_L: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = tpm_pkg::TAP_L;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = tpm_pkg::TAP_K;
        state_next  = S_RD_KL;
      end
      S_RD_KL: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = tpm_pkg::TAP_KL;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = tpm_pkg::TAP_L;
        state_next  = S_CAP_KL;
      end
      S_CAP_KL: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = tpm_pkg::TAP_KL;
        state_next  = S_DIFF;
      end
      S_DIFF: begin
        cmd.calc_d = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.acc_mul = 1'b1;
        state_next  = S_SHAPE;
      end
      S_SHAPE: begin
        cmd.acc_shape = 1'b1;
        state_next    = S_MAG;
      end
      S_MAG: begin
        cmd.take_mag = 1'b1;
        state_next   = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tpm_pkg::DIV_FILT;
        state_next    = S_FWAIT;
      end
      S_FWAIT: begin
        cmd.div_sel = tpm_pkg::DIV_FILT;
        if (status.div_done) state_next = S_PEAK;
      end
      S_PEAK: begin
        cmd.take_peak = 1'b1;
        state_next    = status.last ? S_BPREP : S_OUT;
      end
      S_BPREP: begin
        cmd.base_prep = 1'b1;
        state_next    = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tpm_pkg::DIV_MEAN;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        cmd.div_sel = tpm_pkg::DIV_MEAN;
        if (status.div_done) state_next = S_NUM;
      end
      S_NUM: begin
        cmd.take_num = 1'b1;
        // fewer than two baseline samples: noise is zero, no division
        state_next   = status.n_gt1 ? S_NDIV : S_OUT;
      end
      S_NDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tpm_pkg::DIV_NOISE;
        state_next    = S_NWAIT;
      end
      S_NWAIT: begin
        cmd.div_sel = tpm_pkg::DIV_NOISE;
        if (status.div_done) state_next = S_SQINIT;
      end
      S_SQINIT: begin
        cmd.sqrt_init = 1'b1;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.load_out = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
